/* rtl/gls_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the galloping lower-bound search block.
// No dependencies; used by the channel interfaces, the top level and the checker.
package gls_pkg;

  localparam int unsigned DEPTH    = 65536;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned CW       = 17;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned PREFIX_W = 64;
  localparam int unsigned ROW_W    = 32;
  localparam int unsigned HINT_W   = 16;
  localparam int unsigned KEY_W    = PREFIX_W + ROW_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef logic [CW-1:0]    cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

endpackage

/* rtl/gls_in_if.sv */
`timescale 1ns / 1ps
// Input channel: valid/ready handshake with load and query payload.
// Depends on gls_pkg for field widths.
interface gls_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [gls_pkg::SLOT_W-1:0]     slot;
  logic [gls_pkg::PREFIX_W-1:0]   entry_prefix;
  logic [gls_pkg::ROW_W-1:0]      entry_row;
  logic [gls_pkg::PREFIX_W-1:0]   query_prefix;
  logic [gls_pkg::ROW_W-1:0]      query_row;
  logic [gls_pkg::HINT_W-1:0]     hint;

  modport source (
    output valid, func, slot, entry_prefix, entry_row, query_prefix, query_row, hint,
    input  ready
  );

  modport sink (
    input  valid, func, slot, entry_prefix, entry_row, query_prefix, query_row, hint,
    output ready
  );
endinterface

/* rtl/gls_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the lower-bound position.
// Depends on gls_pkg for the position width.
interface gls_out_if;
  logic                    valid;
  logic                    ready;
  logic [gls_pkg::CW-1:0]  position;

  modport source (
    output valid, position,
    input  ready
  );

  modport sink (
    input  valid, position,
    output ready
  );
endinterface

/* rtl/galloping_lower_bound_search_top.sv */
`timescale 1ns / 1ps
// Top level of the galloping lower-bound search over a sorted compound-key table.
// Depends on gls_pkg, gls_in_if and gls_out_if.
//
// A load transfer writes one 96-bit key (prefix, then row) into the on-chip table and
// gives no result. A query transfer gallops from the clamped hint with doubling
// steps and then binary-searches the bracketed range, returning the first index whose key
// is not less than the query key (0 to entry_count, count saturated to the table depth).
// All table reads go through one read port with registered data and one 96-bit compare.
// Each probe after the first passes through a step or bisect setup state before its
// compare, and a bracket check state decides between another bisect probe and the
// result handoff. A finished query's result waits while the previous result still
// waits on the output. The input is not ready while a query runs; loads are taken
// while an earlier result still waits on the output. Entries are undefined until
// loaded; write entry_count only while the block is idle.
module galloping_lower_bound_search_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [gls_pkg::CW-1:0]    cfg_data_i,
  gls_in_if.sink                    in_i,
  gls_out_if.source                 out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_RSTEP,
    ST_LSTEP,
    ST_BCHK,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MD_START,
    MD_RIGHT,
    MD_LEFT,
    MD_BIN
  } mode_e;

  state_e                   state_q, state_d;
  mode_e                    mode_q, mode_d;
  gls_pkg::cnt_t            count_q, count_d;
  gls_pkg::cnt_t            n_q, n_d;
  logic [gls_pkg::AW-1:0]   pos_q, pos_d;
  gls_pkg::cnt_t            room_q, room_d;
  gls_pkg::cnt_t            step_q, step_d;
  gls_pkg::cnt_t            lo_q, lo_d;
  gls_pkg::cnt_t            hi_q, hi_d;
  logic [gls_pkg::AW-1:0]   probe_q, probe_d;
  gls_pkg::key_t            qkey_q, qkey_d;
  gls_pkg::cnt_t            res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  gls_pkg::cnt_t            out_pos_q, out_pos_d;
  gls_pkg::key_t            rdata_q;

  gls_pkg::key_t            key_mem [gls_pkg::DEPTH];

  logic                     accept;
  logic                     load_wr;
  gls_pkg::cnt_t            n_sat;
  gls_pkg::cnt_t            nm1;
  gls_pkg::cnt_t            hint_ext;
  gls_pkg::cnt_t            pos_init;
  gls_pkg::cnt_t            pos_ext;
  gls_pkg::cnt_t            probe_ext;
  gls_pkg::cnt_t            probe_inc;
  gls_pkg::cnt_t            mid;
  gls_pkg::cnt_t            left_probe;
  gls_pkg::cnt_t            right_probe;
  logic                     below;

  assign in_i.ready     = (state_q == ST_IDLE);
  assign accept         = in_i.valid && in_i.ready;
  assign load_wr        = accept && (in_i.func == gls_pkg::FUNC_LOAD)
                          && (gls_pkg::CW'(in_i.slot) < gls_pkg::DEPTH_C);
  assign out_o.valid    = out_valid_q;
  assign out_o.position = out_pos_q;

  assign n_sat       = (count_q > gls_pkg::DEPTH_C) ? gls_pkg::DEPTH_C : count_q;
  assign nm1         = n_sat - gls_pkg::CW'(1);
  assign hint_ext    = gls_pkg::CW'(in_i.hint);
  assign pos_init    = (hint_ext < nm1) ? hint_ext : nm1;
  assign pos_ext     = gls_pkg::CW'(pos_q);
  assign probe_ext   = gls_pkg::CW'(probe_q);
  assign probe_inc   = probe_ext + gls_pkg::CW'(1);
  assign mid         = lo_q + ((hi_q - lo_q) >> 1);
  assign left_probe  = (step_q > pos_ext) ? '0 : pos_ext - step_q;
  assign right_probe = pos_ext + step_q;
  assign below       = rdata_q < qkey_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    n_d         = n_q;
    pos_d       = pos_q;
    room_d      = room_q;
    step_d      = step_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    probe_d     = probe_q;
    qkey_d      = qkey_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_pos_d   = out_pos_q;

    if (cfg_we_i) begin
      count_d = cfg_data_i;
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.func == gls_pkg::FUNC_QUERY)) begin
          qkey_d = {in_i.query_prefix, in_i.query_row};
          n_d    = n_sat;
          if (n_sat == '0) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            pos_d   = pos_init[gls_pkg::AW-1:0];
            room_d  = nm1 - pos_init;
            probe_d = pos_init[gls_pkg::AW-1:0];
            mode_d  = MD_START;
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        case (mode_q)
          MD_START: begin
            if (below) begin
              lo_d   = probe_inc;
              step_d = gls_pkg::CW'(1);
              if (probe_inc >= n_q) begin
                res_d   = n_q;
                state_d = ST_DONE;
              end else begin
                state_d = ST_RSTEP;
              end
            end else begin
              hi_d   = probe_inc;
              step_d = gls_pkg::CW'(1);
              if (pos_q == '0) begin
                res_d   = '0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_LSTEP;
              end
            end
          end
          MD_RIGHT: begin
            if (!below) begin
              hi_d    = probe_inc;
              state_d = ST_BCHK;
            end else begin
              lo_d = probe_inc;
              if (probe_inc >= n_q) begin
                res_d   = n_q;
                state_d = ST_DONE;
              end else if (step_q > (n_q >> 1)) begin
                hi_d    = n_q;
                state_d = ST_BCHK;
              end else begin
                step_d  = step_q << 1;
                state_d = ST_RSTEP;
              end
            end
          end
          MD_LEFT: begin
            if (below) begin
              lo_d    = probe_inc;
              state_d = ST_BCHK;
            end else begin
              hi_d = probe_inc;
              if (probe_q == '0) begin
                res_d   = '0;
                state_d = ST_DONE;
              end else begin
                if (step_q > (pos_ext >> 1)) begin
                  step_d = pos_ext + gls_pkg::CW'(1);
                end else begin
                  step_d = step_q << 1;
                end
                state_d = ST_LSTEP;
              end
            end
          end
          MD_BIN: begin
            if (below) begin
              lo_d = probe_inc;
            end else begin
              hi_d = probe_ext;
            end
            state_d = ST_BCHK;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_RSTEP: begin
        if (step_q > room_q) begin
          hi_d    = n_q;
          state_d = ST_BCHK;
        end else begin
          probe_d = right_probe[gls_pkg::AW-1:0];
          mode_d  = MD_RIGHT;
          state_d = ST_CMP;
        end
      end
      ST_LSTEP: begin
        probe_d = left_probe[gls_pkg::AW-1:0];
        mode_d  = MD_LEFT;
        state_d = ST_CMP;
      end
      ST_BCHK: begin
        if (lo_q < hi_q) begin
          probe_d = mid[gls_pkg::AW-1:0];
          mode_d  = MD_BIN;
          state_d = ST_CMP;
        end else begin
          res_d   = lo_q;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MD_START;
      count_q     <= gls_pkg::CW'(1);
      n_q         <= '0;
      pos_q       <= '0;
      room_q      <= '0;
      step_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      probe_q     <= '0;
      qkey_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      n_q         <= n_d;
      pos_q       <= pos_d;
      room_q      <= room_d;
      step_q      <= step_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      probe_q     <= probe_d;
      qkey_q      <= qkey_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_pos_q   <= out_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      key_mem[gls_pkg::AW'(in_i.slot)] <= {in_i.entry_prefix, in_i.entry_row};
    end
    rdata_q <= key_mem[probe_d];
  end

endmodule

/* rtl/gls_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the galloping lower-bound search top level, and its bind.
// Depends on gls_pkg and galloping_lower_bound_search_top.
module gls_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_func_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [gls_pkg::CW-1:0]  out_position_i
);

  // a query holds off the next transfer
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == gls_pkg::FUNC_QUERY) |=> !in_ready_i)
    else $error("input ready right after a query transfer");

  // a load leaves the input open
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == gls_pkg::FUNC_LOAD) |=> in_ready_i)
    else $error("input not ready after a load transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_position_i))
    else $error("stalled result dropped or changed");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_position_i <= gls_pkg::DEPTH_C)
    else $error("position beyond table depth");

  // a new result only appears at the end of a busy query
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while input was idle");

endmodule

bind galloping_lower_bound_search_top gls_checker u_gls_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_func_i      (in_i.func),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_position_i (out_o.position)
);

/* sim/tb_galloping_lower_bound_search_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for galloping_lower_bound_search_top: loads tables, queries lower
// bounds and checks each position against a predictor run at every accepted query transfer.
// Depends on gls_pkg, gls_in_if, gls_out_if and the top level.
module tb_galloping_lower_bound_search_top;

  localparam int RAND_ITEMS = 1500;
  localparam int CALM_AT    = 1300;
  localparam int SETTLE     = 100;
  localparam int WATCHDOG   = 5000;
  localparam int LONG_HOLD  = 600;

  typedef struct packed {
    gls_pkg::func_e                 func;
    logic [gls_pkg::SLOT_W-1:0]     slot;
    gls_pkg::key_t                  entry;
    gls_pkg::key_t                  probe;
    logic [gls_pkg::HINT_W-1:0]     hint;
  } xfer_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we = 1'b0;
  gls_pkg::cnt_t  cfg_data = '0;
  logic           drv_valid = 1'b0;
  xfer_t          drv_item = '0;
  logic           rcv_ready = 1'b0;

  xfer_t          pending[$];
  gls_pkg::cnt_t  want_pos[$];
  gls_pkg::key_t  key_mirror [gls_pkg::DEPTH];
  gls_pkg::key_t  key_plan [gls_pkg::DEPTH];
  gls_pkg::cnt_t  count_model = gls_pkg::cnt_t'(1);

  int          drv_gap = 0;
  int          rcv_stall = 0;
  int          hold_left = 0;
  int          hold_tick = 0;
  int          hold_seen = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  bit          calm = 1'b0;
  int          quiet = 0;
  int          errors = 0;
  int          n_loads = 0;
  int          n_queries = 0;
  int          n_checked = 0;
  int          n_queued = 0;
  int          cfg_writes = 0;

  gls_in_if  in_bus ();
  gls_out_if res_bus ();

  assign in_bus.valid        = drv_valid;
  assign in_bus.func         = drv_item.func;
  assign in_bus.slot         = drv_item.slot;
  assign in_bus.entry_prefix = drv_item.entry[gls_pkg::KEY_W-1:gls_pkg::ROW_W];
  assign in_bus.entry_row    = drv_item.entry[gls_pkg::ROW_W-1:0];
  assign in_bus.query_prefix = drv_item.probe[gls_pkg::KEY_W-1:gls_pkg::ROW_W];
  assign in_bus.query_row    = drv_item.probe[gls_pkg::ROW_W-1:0];
  assign in_bus.hint         = drv_item.hint;
  assign res_bus.ready       = rcv_ready;

  galloping_lower_bound_search_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (res_bus)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit entry_below(int idx, gls_pkg::key_t q);
    return key_mirror[idx] < q;
  endfunction

  function automatic int bisect(int lo, int hi, gls_pkg::key_t q);
    int mid;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_below(mid, q)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic gls_pkg::cnt_t lower_bound_of(gls_pkg::cnt_t cnt,
                                                   logic [gls_pkg::HINT_W-1:0] hint,
                                                   gls_pkg::key_t q);
    int n, pos, step, probe, lo, hi, res;
    bit done;
    n = (int'(cnt) > int'(gls_pkg::DEPTH)) ? int'(gls_pkg::DEPTH) : int'(cnt);
    if (n == 0) return '0;
    pos = (int'(hint) < n - 1) ? int'(hint) : n - 1;
    step = 1;
    if (entry_below(pos, q)) begin
      lo = pos + 1;
      res = n;
      done = (lo >= n);
      while (!done) begin
        if (step > n - 1 - pos) begin
          res = bisect(lo, n, q);
          done = 1'b1;
        end else begin
          probe = pos + step;
          if (!entry_below(probe, q)) begin
            res = bisect(lo, probe + 1, q);
            done = 1'b1;
          end else begin
            lo = probe + 1;
            if (lo >= n) begin
              res = n;
              done = 1'b1;
            end else if (step > n / 2) begin
              res = bisect(lo, n, q);
              done = 1'b1;
            end else begin
              step = step * 2;
            end
          end
        end
      end
    end else begin
      hi = pos + 1;
      res = 0;
      done = (pos == 0);
      while (!done) begin
        probe = (step > pos) ? 0 : pos - step;
        if (entry_below(probe, q)) begin
          res = bisect(probe + 1, hi, q);
          done = 1'b1;
        end else begin
          hi = probe + 1;
          if (probe == 0) done = 1'b1;
          else if (step > pos / 2) step = pos + 1;
          else step = step * 2;
        end
      end
    end
    return gls_pkg::cnt_t'(res);
  endfunction

  // Driver: hold the item until transfer, predict at the transfer edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_gap   <= 0;
    end else begin
      if (drv_valid && in_bus.ready) begin
        if (drv_item.func == gls_pkg::FUNC_LOAD) begin
          key_mirror[drv_item.slot] = drv_item.entry;
          n_loads++;
        end else begin
          want_pos = {want_pos, lower_bound_of(count_model, drv_item.hint, drv_item.probe)};
          n_queries++;
        end
      end
      if (!drv_valid || in_bus.ready) begin
        if (drv_gap != 0) begin
          drv_gap   <= drv_gap - 1;
          drv_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < snd_idle_pct) begin
          drv_gap   <= $urandom_range(0, 15);
          drv_valid <= 1'b0;
        end else begin
          drv_item  <= pending.pop_front();
          drv_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each position transfer, drive ready with stalls and the long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
      rcv_stall <= 0;
      hold_left <= 0;
    end else begin
      if (res_bus.valid && rcv_ready) begin
        if (want_pos.size() == 0) begin
          $display("%0t: unexpected position %0d, expected nothing", $time, res_bus.position);
          errors++;
        end else begin
          gls_pkg::cnt_t exp_pos;
          exp_pos = want_pos.pop_front();
          n_checked++;
          if (res_bus.position !== exp_pos) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, exp_pos, res_bus.position);
            errors++;
          end
        end
      end
      if (hold_seen != hold_tick) begin
        hold_seen <= hold_tick;
        hold_left <= LONG_HOLD;
        rcv_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rcv_ready <= 1'b0;
      end else if (rcv_stall != 0) begin
        rcv_stall <= rcv_stall - 1;
        rcv_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rcv_idle_pct) begin
        rcv_stall <= $urandom_range(0, 15);
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (drv_valid && in_bus.ready) || (res_bus.valid && rcv_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
      $display("galloping_lower_bound_search_top verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_load(logic [gls_pkg::SLOT_W-1:0] slot, gls_pkg::key_t k);
    xfer_t t;
    t       = '0;
    t.func  = gls_pkg::FUNC_LOAD;
    t.slot  = slot;
    t.entry = k;
    t.probe = gls_pkg::key_t'({$urandom, $urandom, $urandom});
    t.hint  = gls_pkg::HINT_W'($urandom);
    key_plan[slot] = k;
    pending = {pending, t};
    n_queued++;
  endtask

  task automatic push_query(gls_pkg::key_t q, logic [gls_pkg::HINT_W-1:0] hint);
    xfer_t t;
    t       = '0;
    t.func  = gls_pkg::FUNC_QUERY;
    t.slot  = gls_pkg::SLOT_W'($urandom);
    t.entry = gls_pkg::key_t'({$urandom, $urandom, $urandom});
    t.probe = q;
    t.hint  = hint;
    pending = {pending, t};
    n_queued++;
  endtask

  // Query near stored keys, with hints near the answer, at random and at the ends.
  task automatic push_probe(int n);
    int m, k, t;
    gls_pkg::key_t q;
    m = (n > int'(gls_pkg::DEPTH)) ? int'(gls_pkg::DEPTH) : n;
    k = (m == 0) ? 0 : $urandom_range(0, m - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: q = key_plan[k];
      3:       q = key_plan[k] - gls_pkg::key_t'(1);
      4:       q = key_plan[k] + gls_pkg::key_t'(1);
      5:       q = {key_plan[k][gls_pkg::KEY_W-1:gls_pkg::ROW_W], 32'($urandom)};
      6, 7:    q = gls_pkg::key_t'({$urandom, $urandom, $urandom});
      8:       q = '0;
      default: q = '1;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: t = k + int'($urandom_range(0, 8)) - 4;
      4, 5:       t = int'($urandom_range(0, 65535));
      6:          t = 65535;
      7:          t = 0;
      default:    t = (m == 0) ? 0 : m - 1 + int'($urandom_range(0, 1));
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    push_query(q, gls_pkg::HINT_W'(t));
  endtask

  task automatic plan_sorted(int m, bit zero_start, bit ones_end);
    gls_pkg::key_t cur;
    int sh, r;
    sh  = $urandom_range(0, 63 - $clog2(m + 1));
    cur = zero_start ? '0
                     : (gls_pkg::key_t'({$urandom, $urandom}) >> $urandom_range(0, 63));
    for (int i = 0; i < m; i++) begin
      r = $urandom_range(0, 3);
      if (i != 0 && r == 1) cur = cur + gls_pkg::key_t'($urandom_range(1, 3));
      else if (i != 0 && r > 1) cur = cur + (gls_pkg::key_t'($urandom) << sh);
      if (ones_end && i == m - 1) cur = '1;
      push_load(gls_pkg::SLOT_W'(i), cur);
    end
  endtask

  task automatic drain_and_settle();
    do @(negedge clk_i);
    while (pending.size() != 0 || drv_valid || want_pos.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_count(gls_pkg::cnt_t v);
    drain_and_settle();
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    count_model = v;
    cfg_writes++;
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 4))
      0, 1:    return 0;
      2:       return 10;
      3:       return 30;
      default: return 60;
    endcase
  endfunction

  initial begin
    int n, m, r, base, nq;
    gls_pkg::key_t k0, k1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: entry_count at its reset value of one.
    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    k0 = {64'h8000_0000_0000_0000, 32'h8000_0000};
    push_load('0, k0);
    push_query(k0, 16'd0);
    push_query(k0 - gls_pkg::key_t'(1), 16'hFFFF);
    push_query(k0 + gls_pkg::key_t'(1), 16'd0);
    push_query('0, 16'd0);
    push_query('1, 16'hFFFF);

    set_count(gls_pkg::cnt_t'(0));
    push_query(gls_pkg::key_t'({$urandom, $urandom, $urandom}), 16'hFFFF);
    push_query('0, 16'd0);

    // Duplicates, row-only order and both key extremes in a four-entry table.
    set_count(gls_pkg::cnt_t'(4));
    push_load(16'd0, {64'h0, 32'h0});
    push_load(16'd1, {64'h0, 32'h0});
    push_load(16'd2, {64'h0, 32'hFFFF_FFFF});
    push_load(16'd3, {64'hFFFF_FFFF_FFFF_FFFF, 32'h0});
    push_query({64'h0, 32'h0}, 16'd3);
    push_query({64'h0, 32'h1}, 16'd0);
    push_query({64'h0, 32'hFFFF_FFFF}, 16'hFFFF);
    push_query({64'h1, 32'h0}, 16'd1);
    push_query('1, 16'd2);
    push_query({64'hFFFF_FFFF_FFFF_FFFF, 32'h0}, 16'd0);

    // Full depth and a count above it: queries that settle on the first or last slot.
    set_count(gls_pkg::DEPTH_C);
    k0 = {64'h0000_0000_0000_1000, 32'h0000_0010};
    k1 = {64'hFFFF_FFFF_FFFF_FF00, 32'h0000_0005};
    push_load(16'd0, k0);
    push_load(16'hFFFF, k1);
    push_query(k0, 16'd0);
    push_query('0, 16'd0);
    push_query(k1 + gls_pkg::key_t'(1), 16'hFFFF);
    push_query('1, 16'hFFFF);
    set_count(gls_pkg::cnt_t'(131071));
    push_query(k0 - gls_pkg::key_t'(1), 16'd0);
    push_query('1, 16'hFFFF);
    push_query(k1 + gls_pkg::key_t'(1), 16'hFFFF);

    // A 256-entry table; hold the result side off while queries keep coming.
    set_count(gls_pkg::cnt_t'(256));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    plan_sorted(256, 1'b1, 1'b1);
    snd_idle_pct = 10;
    rcv_idle_pct = 10;
    hold_tick++;
    repeat (120) push_probe(256);

    base = n_queued;
    while (n_queued - base < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 3) n = 0;
      else if (r < 60) n = $urandom_range(1, 16);
      else if (r < 88) n = $urandom_range(17, 128);
      else n = $urandom_range(129, 256);
      set_count(gls_pkg::cnt_t'(n));
      snd_idle_pct = pick_idle();
      rcv_idle_pct = pick_idle();
      m = (n > int'(gls_pkg::DEPTH)) ? int'(gls_pkg::DEPTH) : n;
      if (m != 0 && m <= 128) begin
        if ($urandom_range(0, 6) != 0) begin
          plan_sorted(m, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end else begin
          for (int i = 0; i < m; i++)
            push_load(gls_pkg::SLOT_W'(i), gls_pkg::key_t'({$urandom, $urandom, $urandom}));
        end
      end
      nq = $urandom_range(4, 24);
      repeat (nq) begin
        if ($urandom_range(0, 9) == 0)
          push_load(gls_pkg::SLOT_W'($urandom),
                    gls_pkg::key_t'({$urandom, $urandom, $urandom}));
        push_probe(n);
      end
      if (n_queued - base >= CALM_AT) calm = 1'b1;
    end

    drain_and_settle();
    $display("Summary: %0d loads and %0d queries transferred, %0d positions checked",
             n_loads, n_queries, n_checked);
    $display("Summary: %0d entry_count writes from 0 to 131071, tables up to 256 entries",
             cfg_writes);
    if (errors == 0) begin
      $display("galloping_lower_bound_search_top verification clean");
    end else begin
      $display("galloping_lower_bound_search_top verification failed");
    end
    $finish;
  end

endmodule
